@@ rtl/positional_ordered_list_macros.svh @@
// ----------------------------------------------------------------------------
// positional_ordered_list_macros
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ORDERED_LIST_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_MACROS_SVH

// same-cycle implication
`define POL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define POL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/pol_pkg.sv @@
// ----------------------------------------------------------------------------
// pol_pkg
// shared types and constants of the positional ordered list
// ----------------------------------------------------------------------------
package pol_pkg;

	localparam int CAPACITY = 64;

	localparam int OpcodeW = 2;
	localparam int PosW    = 7;
	localparam int DataW   = 32;
	localparam int FoundW  = 8;
	localparam int LenW    = 7;

	localparam int CntW = $clog2(CAPACITY + 1);
	localparam int IdxW = $clog2(CAPACITY);
	localparam int CmpW = ((CntW > PosW) ? CntW : PosW) + 1;

	localparam logic [DataW-1:0] OutOfRangeValue = {1'b0, {(DataW-1){1'b1}}};

	typedef enum logic [OpcodeW-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_GET    = 2'd2,
		OP_SEARCH = 2'd3
	} opcode_t;

	typedef logic [DataW-1:0] data_t;

	typedef struct packed {
		logic load;
		logic take_left;
		logic take_right;
		logic occupied;
	} cell_ctl_t;

endpackage

@@ rtl/pol_if.sv @@
// ----------------------------------------------------------------------------
// pol_if
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface pol_req_if;
	logic                                valid;
	logic                                ready;
	logic        [pol_pkg::OpcodeW-1:0] opcode;
	logic        [pol_pkg::PosW-1:0]    position;
	logic signed [pol_pkg::DataW-1:0]   value;

	modport source (output valid, opcode, position, value, input ready);
	modport sink   (input valid, opcode, position, value, output ready);
endinterface

interface pol_res_if;
	logic                               valid;
	logic                               ready;
	logic signed [pol_pkg::DataW-1:0]  read_value;
	logic signed [pol_pkg::FoundW-1:0] found_position;
	logic                               ok;
	logic        [pol_pkg::LenW-1:0]   length;

	modport source (output valid, read_value, found_position, ok, length, input ready);
	modport sink   (input valid, read_value, found_position, ok, length, output ready);
endinterface

@@ rtl/positional_ordered_list.sv @@
// ----------------------------------------------------------------------------
// positional_ordered_list
// ordered list of signed 32-bit values with insert, delete, get and search
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, one element per cell, with the
// element count in a register. Every request is done when it is taken: an
// insert or delete moves all cells after the position by one place at once,
// a get selects one cell, and a search compares all occupied cells in
// parallel and picks the lowest match. A new request is taken each cycle as
// long as the result register is empty or being drained; the path through
// the cell compares and the match priority encoder sets the clock period.
// Each request gives exactly one result; length is the count after it.
module positional_ordered_list (
	input logic      clk,
	input logic      arst_n,
	pol_req_if.sink  request,
	pol_res_if.source result
);
	import pol_pkg::*;

	logic [CntW-1:0] count_q;
	logic            res_valid_q;
	data_t           read_value_q;
	logic [FoundW-1:0] found_q;
	logic            ok_q;

	logic            accept;
	opcode_t         op;
	logic [CmpW-1:0] pos_w;
	logic [CmpW-1:0] cnt_w;
	logic [CmpW-1:0] slot_w;
	logic [CmpW-1:0] idx_w;
	logic            full;
	logic            in_range;
	logic            ins_do;
	logic            del_do;

	data_t           cell_data [CAPACITY];
	logic [CAPACITY-1:0] cell_match;
	cell_ctl_t       cell_ctl [CAPACITY];

	logic            hit;
	logic [IdxW-1:0] hit_idx;

	data_t           rv_d;
	logic [FoundW-1:0] fp_d;
	logic            ok_d;
	logic [CntW-1:0] count_d;

	assign request.ready = !res_valid_q || result.ready;
	assign accept        = request.valid && request.ready;
	assign op            = opcode_t'(request.opcode);

	assign pos_w    = CmpW'(request.position);
	assign cnt_w    = CmpW'(count_q);
	assign idx_w    = pos_w - CmpW'(1);
	assign full     = cnt_w >= CmpW'(CAPACITY);
	assign in_range = (pos_w >= CmpW'(1)) && (pos_w <= cnt_w);
	assign ins_do   = accept && (op == OP_INSERT) && !full;
	assign del_do   = accept && (op == OP_DELETE) && in_range;

	always_comb begin
		if (pos_w <= CmpW'(1) || cnt_w == '0) begin
			slot_w = '0;
		end else if (idx_w > cnt_w) begin
			slot_w = cnt_w;
		end else begin
			slot_w = idx_w;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CmpW-1:0] Pos = CmpW'(i);
		data_t left_d;
		data_t right_d;

		assign cell_ctl[i].load       = ins_do && (Pos == slot_w);
		assign cell_ctl[i].take_left  = ins_do && (Pos > slot_w);
		assign cell_ctl[i].take_right = del_do && (Pos >= idx_w);
		assign cell_ctl[i].occupied   = Pos < cnt_w;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_inner_l
			assign left_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_inner_r
			assign right_d = cell_data[i+1];
		end

		pol_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[i]),
			.left_data  (left_d),
			.right_data (right_d),
			.new_data   (data_t'(request.value)),
			.key        (data_t'(request.value)),
			.data       (cell_data[i]),
			.match      (cell_match[i])
		);
	end

	// lowest matching slot wins
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (cell_match[i]) begin
				hit     = 1'b1;
				hit_idx = IdxW'(i);
			end
		end
	end

	always_comb begin
		rv_d    = '0;
		fp_d    = '0;
		ok_d    = 1'b0;
		count_d = count_q;
		unique case (op)
			OP_INSERT: begin
				ok_d = !full;
				if (!full) begin
					count_d = count_q + CntW'(1);
				end
			end
			OP_DELETE: begin
				ok_d = in_range;
				if (in_range) begin
					count_d = count_q - CntW'(1);
				end
			end
			OP_GET: begin
				ok_d = in_range;
				rv_d = in_range ? cell_data[idx_w[IdxW-1:0]] : OutOfRangeValue;
			end
			OP_SEARCH: begin
				ok_d = hit;
				fp_d = hit ? (FoundW'(hit_idx) + FoundW'(1)) : '1;
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= rv_d;
			found_q      <= fp_d;
			ok_q         <= ok_d;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.read_value     = read_value_q;
	assign result.found_position = found_q;
	assign result.ok             = ok_q;
	assign result.length         = LenW'(count_q);

endmodule

@@ rtl/pol_cell.sv @@
// ----------------------------------------------------------------------------
// pol_cell
// one list slot: holds an element, shifts from a neighbor, compares a key
// ----------------------------------------------------------------------------
module pol_cell (
	input  logic               clk,
	input  pol_pkg::cell_ctl_t ctl,
	input  pol_pkg::data_t     left_data,
	input  pol_pkg::data_t     right_data,
	input  pol_pkg::data_t     new_data,
	input  pol_pkg::data_t     key,
	output pol_pkg::data_t     data,
	output logic               match
);
	import pol_pkg::*;

	data_t data_q;

	always_ff @(posedge clk) begin
		priority if (ctl.load) begin
			data_q <= new_data;
		end else if (ctl.take_left) begin
			data_q <= left_data;
		end else if (ctl.take_right) begin
			data_q <= right_data;
		end else begin
			data_q <= data_q;
		end
	end

	assign data  = data_q;
	assign match = ctl.occupied && (data_q == key);

endmodule

@@ rtl/pol_checker.sv @@
// ----------------------------------------------------------------------------
// pol_checker
// port-level checks of the positional ordered list
// ----------------------------------------------------------------------------
`include "positional_ordered_list_macros.svh"

module pol_checker (
	input logic       clk,
	input logic       arst_n,
	pol_req_if.sink   request,
	pol_res_if.source result
);
	import pol_pkg::*;

	// held result keeps its payload
	`POL_ASSERT_NEXT(a_res_hold, clk, arst_n, result.valid && !result.ready, result.valid && $stable(result.read_value) && $stable(result.found_position) && $stable(result.ok))

	// count never passes capacity
	`POL_ASSERT_NOW(a_len_cap, clk, arst_n, result.valid, result.length <= LenW'(CAPACITY))

	// a found position is a success inside the list
	`POL_ASSERT_NOW(a_found_in_list, clk, arst_n, result.valid && result.found_position != '0 && result.found_position != '1, result.ok && (FoundW'(result.length) >= result.found_position))

	// a nonzero read on failure is the out-of-range marker
	`POL_ASSERT_NOW(a_get_miss, clk, arst_n, result.valid && !result.ok && result.read_value != '0, result.read_value == OutOfRangeValue && result.found_position == '0)

endmodule

bind positional_ordered_list pol_checker u_pol_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.request (request),
	.result  (result)
);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives insert, delete, get and search requests into the positional ordered
// list and checks every result against a queue-based model of the list.
// A short directed run covers an empty list, the front, middle and end
// positions, out-of-range positions, duplicate values and search misses.
// Random requests then fill and drain the list under varying handshake stalls.
// ----------------------------------------------------------------------------
module testbench;
	import pol_pkg::*;

	localparam int IdleLimit = 2000;
	localparam int PhaseItems = 500;

	typedef enum int {MODE_FILL, MODE_MIXED, MODE_DRAIN} traffic_mode_t;

	typedef struct packed {
		logic signed [DataW-1:0]  read_value;
		logic signed [FoundW-1:0] found_position;
		logic                     ok;
		logic [LenW-1:0]          length;
	} list_result_t;

	class list_scoreboard;
		logic signed [DataW-1:0] contents[$];
		list_result_t expected_q[$];
		int errors;

		function int size();
			return contents.size();
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function logic [DataW-1:0] element_at(int idx);
			return contents[idx];
		endfunction

		function void note_request(opcode_t op, logic [PosW-1:0] pos, logic [DataW-1:0] val);
			list_result_t r;
			int count;
			int p;
			int slot;
			r = '0;
			count = contents.size();
			p = int'(pos);
			case (op)
				OP_INSERT: begin
					if (count < CAPACITY) begin
						if (p <= 1 || count == 0)
							slot = 0;
						else if (p - 1 > count)
							slot = count;
						else
							slot = p - 1;
						contents.insert(slot, val);
						r.ok = 1'b1;
					end
				end
				OP_DELETE: begin
					if (p >= 1 && p <= count) begin
						contents.delete(p - 1);
						r.ok = 1'b1;
					end
				end
				OP_GET: begin
					if (p >= 1 && p <= count) begin
						r.read_value = contents[p - 1];
						r.ok = 1'b1;
					end else begin
						r.read_value = OutOfRangeValue;
					end
				end
				default: begin
					r.found_position = '1;
					for (int i = 0; i < count; i++) begin
						if (contents[i] == val) begin
							r.found_position = FoundW'(i + 1);
							r.ok = 1'b1;
							break;
						end
					end
				end
			endcase
			r.length = LenW'(contents.size());
			expected_q.push_back(r);
		endfunction

		function void check_result(list_result_t got);
			list_result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: result with no request pending", $time);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.read_value !== want.read_value) begin
				$display("%0t: read_value expected %0d actual %0d", $time,
					want.read_value, got.read_value);
				errors++;
			end
			if (got.found_position !== want.found_position) begin
				$display("%0t: found_position expected %0d actual %0d", $time,
					want.found_position, got.found_position);
				errors++;
			end
			if (got.ok !== want.ok) begin
				$display("%0t: ok expected %0d actual %0d", $time, want.ok, got.ok);
				errors++;
			end
			if (got.length !== want.length) begin
				$display("%0t: length expected %0d actual %0d", $time,
					want.length, got.length);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int sender_idle_pct;
	int receiver_stall_pct;
	int idle_cycles;
	list_scoreboard sb;

	pol_req_if req_ch();
	pol_res_if res_ch();

	positional_ordered_list DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_ch),
		.result  (res_ch)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_INSERT;
		req_ch.position = '0;
		req_ch.value = '0;
		res_ch.ready = 1'b0;
		sender_idle_pct = 32;
		receiver_stall_pct = 52;
		idle_cycles = 0;
	end

	always #2 clk = ~clk;

	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_result({res_ch.read_value, res_ch.found_position, res_ch.ok,
				res_ch.length});
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_request(opcode_t op, logic [PosW-1:0] pos, logic [DataW-1:0] val);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.position <= pos;
		req_ch.value <= val;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(op, pos, val);
		@(negedge clk);
	endtask

	task automatic random_request(traffic_mode_t mode);
		int count;
		int roll;
		opcode_t op;
		logic [PosW-1:0] pos;
		logic [DataW-1:0] val;
		count = sb.size();
		roll = $urandom_range(99);
		case (mode)
			MODE_FILL:
				op = (roll < 70) ? OP_INSERT : (roll < 80) ? OP_DELETE :
					(roll < 90) ? OP_GET : OP_SEARCH;
			MODE_DRAIN:
				op = (roll < 70) ? OP_DELETE : (roll < 80) ? OP_INSERT :
					(roll < 90) ? OP_GET : OP_SEARCH;
			default:
				op = opcode_t'($urandom_range(3));
		endcase
		roll = $urandom_range(99);
		if (roll < 70)
			pos = PosW'($urandom_range(count + 1, 1));
		else if (roll < 80)
			pos = PosW'($urandom_range(1));
		else
			pos = PosW'($urandom_range(127));
		roll = $urandom_range(99);
		if (roll < 25)
			val = $urandom_range(8) - 4;
		else if (roll < 35)
			val = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
		else if (roll < 65 && count > 0)
			val = sb.element_at($urandom_range(count - 1));
		else
			val = $urandom;
		send_request(op, pos, val);
	endtask

	task automatic random_phase(int items);
		int seg;
		int seg_len;
		seg = 0;
		while (items > 0) begin
			seg_len = $urandom_range(200, 60);
			if (seg_len > items)
				seg_len = items;
			repeat (seg_len) random_request(traffic_mode_t'(seg % 3));
			items -= seg_len;
			seg++;
		end
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty list
		send_request(OP_GET, 7'd0, 32'd0);
		send_request(OP_GET, 7'd1, 32'd0);
		send_request(OP_DELETE, 7'd1, 32'd0);
		send_request(OP_SEARCH, 7'd0, 32'd0);
		// front, append and middle inserts with extreme values
		send_request(OP_INSERT, 7'd5, 32'h7fff_ffff);
		send_request(OP_INSERT, 7'd0, 32'h8000_0000);
		send_request(OP_INSERT, 7'd1, 32'hffff_ffff);
		send_request(OP_INSERT, 7'd127, 32'd0);
		send_request(OP_INSERT, 7'd3, 32'h7fff_ffff);
		send_request(OP_INSERT, 7'd6, 32'd12345);
		// get in and out of range
		send_request(OP_GET, 7'd0, 32'd0);
		send_request(OP_GET, 7'd1, 32'd0);
		send_request(OP_GET, 7'd6, 32'd0);
		send_request(OP_GET, 7'd7, 32'd0);
		send_request(OP_GET, 7'd127, 32'd0);
		// search with duplicate, hit and miss
		send_request(OP_SEARCH, 7'd127, 32'h7fff_ffff);
		send_request(OP_SEARCH, 7'd0, 32'h8000_0000);
		send_request(OP_SEARCH, 7'd0, 32'd42);
		// delete out of range, last, first and middle
		send_request(OP_DELETE, 7'd0, 32'd0);
		send_request(OP_DELETE, 7'd7, 32'd0);
		send_request(OP_DELETE, 7'd6, 32'd0);
		send_request(OP_DELETE, 7'd1, 32'd0);
		send_request(OP_DELETE, 7'd2, 32'd0);
		send_request(OP_DELETE, 7'd127, 32'd0);
		send_request(OP_GET, 7'd2, 32'd0);

		random_phase(PhaseItems);
		sender_idle_pct = 52;
		receiver_stall_pct = 32;
		random_phase(PhaseItems);
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		random_phase(PhaseItems);
		req_ch.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
